// File: rtl/ffsha_pkg.sv
// Package for the first-fit stack heap allocator.
// Holds sizes, codes and the token and write structs shared by the cell and the top level.
// No dependencies.
package ffsha_pkg;

  localparam int MaxBlocks   = 16;
  localparam int HeaderBytes = 24;
  localparam int AddrW       = 21;
  localparam int IdxW        = $clog2(MaxBlocks);
  localparam int CntW        = $clog2(MaxBlocks + 1);
  localparam int NeedW       = AddrW + 2;
  localparam int InDataW     = ((2 * AddrW + 7) / 8) * 8;
  localparam int OutDataW    = ((AddrW + 7) / 8) * 8;

  localparam logic [AddrW-1:0] CapReset = AddrW'(65536);

  typedef enum logic {
    FuncAlloc = 1'b0,
    FuncFree  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    StatOk      = 2'd0,
    StatNoSpace = 2'd1,
    StatUnknown = 2'd2,
    StatNull    = 2'd3
  } status_e;

  typedef struct packed {
    logic             valid;
    func_e            func;
    logic [AddrW-1:0] req;
    logic [AddrW-1:0] addr;
    logic             found;
    logic [AddrW-1:0] grant;
    logic             top_found;
    logic [CntW-1:0]  top_count;
    logic [AddrW-1:0] top_brk;
  } tok_t;

  typedef struct packed {
    logic             en;
    logic [IdxW-1:0]  idx;
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] size;
  } wr_t;

endpackage

// File: rtl/ffsha_cell.sv
// One table entry of the allocator: payload offset, payload size and free flag.
// Checks the passing search token, updates its entry and hands the token down.
// Depends on ffsha_pkg.
module ffsha_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [ffsha_pkg::IdxW-1:0] cell_idx_i,
  input  logic [ffsha_pkg::CntW-1:0] count_i,
  input  ffsha_pkg::wr_t           wr_i,
  input  ffsha_pkg::tok_t          tok_i,
  output ffsha_pkg::tok_t          tok_o
);
  import ffsha_pkg::*;

  logic [AddrW-1:0] start_q;
  logic [AddrW-1:0] size_q;
  logic             free_q;
  tok_t             tok_q, tok_d;
  logic             active, hit_alloc, hit_free, free_post, wr_hit;

  assign active    = {1'b0, cell_idx_i} < count_i;
  assign hit_alloc = tok_i.valid && (tok_i.func == FuncAlloc) && active && !tok_i.found
                     && free_q && (size_q >= tok_i.req);
  assign hit_free  = tok_i.valid && (tok_i.func == FuncFree) && active
                     && (start_q == tok_i.addr);
  assign free_post = hit_free | free_q;
  assign wr_hit    = wr_i.en && (wr_i.idx == cell_idx_i);

  always_comb begin
    tok_d = tok_i;
    if (hit_alloc) begin
      tok_d.found = 1'b1;
      tok_d.grant = start_q;
    end
    if (hit_free) begin
      tok_d.found = 1'b1;
    end
    if ((tok_i.func == FuncFree) && active && !free_post && !tok_i.top_found) begin
      tok_d.top_found = 1'b1;
      tok_d.top_count = {1'b0, cell_idx_i} + CntW'(1);
      tok_d.top_brk   = start_q + size_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      start_q <= wr_i.start;
      size_q  <= wr_i.size;
      free_q  <= 1'b0;
    end else if (hit_alloc) begin
      free_q <= 1'b0;
    end else if (hit_free) begin
      free_q <= 1'b1;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: rtl/first_fit_stack_heap_allocator.sv
// First-fit stack heap allocator: one item at a time. The accepted item is registered, the
// search token walks the row of 16 table cells, one cell a cycle, and then the finish step
// registers the result; a result still waiting at the output when the next one finishes holds the
// finish step. A new item is taken once the previous result sits in the output register.
// Reset (async, active low) empties the heap: block count 0, break 0, capacity 65536.
module first_fit_stack_heap_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ffsha_pkg::AddrW-1:0]     cfg_data_i,    // heap_capacity
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ffsha_pkg::InDataW-1:0]   s_axis_tdata,  // req_size, address, zero pad
  input  logic [0:0]                      s_axis_tuser,  // func
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ffsha_pkg::OutDataW-1:0]  m_axis_tdata,  // address_out, zero pad
  output logic [1:0]                      m_axis_tuser   // status
);
  import ffsha_pkg::*;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRun  = 3'b010,
    StFin  = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [AddrW-1:0] cap_q;
  logic [CntW-1:0]  count_q, count_d;
  logic [AddrW-1:0] brk_q, brk_d;
  tok_t             inj_q, inj_d;
  tok_t             fin_q;
  logic             out_valid_q, out_valid_d;
  status_e          out_status_q, out_status_d;
  logic [AddrW-1:0] out_addr_q, out_addr_d;
  wr_t              wr;
  tok_t             tok_w [MaxBlocks+1];
  logic [MaxBlocks-1:0] tok_vld;
  logic [NeedW-1:0] need;
  logic             in_fire, out_free;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = OutDataW'(out_addr_q);

  assign tok_w[MaxBlocks] = inj_q;

  for (genvar i = 0; i < MaxBlocks; i++) begin : g_cell
    ffsha_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IdxW'(i)),
      .count_i    (count_q),
      .wr_i       (wr),
      .tok_i      (tok_w[i+1]),
      .tok_o      (tok_w[i])
    );
    assign tok_vld[i] = tok_w[i+1].valid;
  end

  always_comb begin
    inj_d           = '0;
    inj_d.valid     = in_fire;
    inj_d.func      = func_e'(s_axis_tuser[0]);
    inj_d.req       = s_axis_tdata[AddrW-1:0];
    inj_d.addr      = s_axis_tdata[2*AddrW-1:AddrW];
  end

  assign need = NeedW'(brk_q) + NeedW'(HeaderBytes) + NeedW'(fin_q.req);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    brk_d        = brk_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    wr           = '0;
    case (state_q)
      StIdle: begin
        if (in_fire) state_d = StRun;
      end
      StRun: begin
        if (tok_w[0].valid) state_d = StFin;
      end
      StFin: begin
        if (out_free) begin
          state_d     = StIdle;
          out_valid_d = 1'b1;
          out_addr_d  = '0;
          if (fin_q.func == FuncFree) begin
            if (fin_q.addr == '0) begin
              out_status_d = StatNull;
            end else if (!fin_q.found) begin
              out_status_d = StatUnknown;
            end else begin
              out_status_d = StatOk;
              count_d      = fin_q.top_found ? fin_q.top_count : '0;
              brk_d        = fin_q.top_found ? fin_q.top_brk : '0;
            end
          end else if (fin_q.found) begin
            out_status_d = StatOk;
            out_addr_d   = fin_q.grant;
          end else if ((count_q >= CntW'(MaxBlocks)) || (need > NeedW'(cap_q))) begin
            out_status_d = StatNoSpace;
          end else begin
            out_status_d = StatOk;
            out_addr_d   = brk_q + AddrW'(HeaderBytes);
            wr.en        = 1'b1;
            wr.idx       = count_q[IdxW-1:0];
            wr.start     = brk_q + AddrW'(HeaderBytes);
            wr.size      = fin_q.req;
            count_d      = count_q + CntW'(1);
            brk_d        = need[AddrW-1:0];
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cap_q       <= CapReset;
      count_q     <= '0;
      brk_q       <= '0;
      inj_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      brk_q       <= brk_d;
      inj_q       <= inj_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) cap_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q    <= out_status_d;
    out_addr_q      <= out_addr_d;
    if (tok_w[0].valid) fin_q <= tok_w[0];
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxBlocks))
    else $error("block count above table size");

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld))
    else $error("more than one search token in the cell row");

  a_state_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$stable(count_q) || !$stable(brk_q)) |-> $past(state_q == StFin))
    else $error("heap state changed outside the finish step");

  a_idle_no_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (tok_vld == '0))
    else $error("search token alive while idle");
`endif

endmodule
